// ===== design/iqd_pkg.sv =====
package iqd_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_ISSUE       = 3'd0;
  localparam logic [2:0] REQ_TICK        = 3'd1;
  localparam logic [2:0] REQ_VECTOR_DONE = 3'd2;
  localparam logic [2:0] REQ_MATRIX_DONE = 3'd3;
  localparam logic [2:0] REQ_MEMORY_DONE = 3'd4;

  // Target codes carried in op_target.
  localparam logic [1:0] TGT_VECTOR  = 2'd0;
  localparam logic [1:0] TGT_MATRIX  = 2'd1;
  localparam logic [1:0] TGT_MEMORY  = 2'd2;
  localparam logic [1:0] TGT_INVALID = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
  localparam logic [2:0] KIND_BAD_TARGET = 3'd1;
  localparam logic [2:0] KIND_QUEUE_FULL = 3'd2;
  localparam logic [2:0] KIND_VEC_DISP   = 3'd3;
  localparam logic [2:0] KIND_MAT_DISP   = 3'd4;
  localparam logic [2:0] KIND_MEM_SEND   = 3'd5;
  localparam logic [2:0] KIND_NOTIFY     = 3'd6;
  localparam logic [2:0] KIND_IDLE       = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACTIVE_VECTOR = 2'd0;
  localparam logic [1:0] REG_ACTIVE_MATRIX = 2'd1;

  localparam logic [3:0] ACTIVE_RESET = 4'd8;
  localparam int         READY_WIDTH  = 8;
  localparam int         RES_SLOTS    = 3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] op_tag;
    logic [1:0] op_target;
    logic [3:0] stream_id;
    logic [2:0] op_thread;
    logic [7:0] vector_ready;
    logic [7:0] matrix_ready;
    logic [7:0] mem_thread_ready;
  } req_t;

  typedef struct packed {
    logic [2:0] res_kind;
    logic [2:0] unit_index;
    logic [7:0] out_tag;
    logic [3:0] out_stream;
    logic [2:0] out_thread;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] tag;
    logic [3:0] stream;
    logic [2:0] thread;
  } entry_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } pick_t;

  // Register value clamped to the usable unit count.
  function automatic logic [3:0] eff_count(input logic [3:0] value, input logic [3:0] limit);
    eff_count = (value > limit) ? limit : value;
  endfunction

  // Lowest ready unit among the first n units.
  function automatic pick_t pick_unit(input logic [7:0] ready, input logic [3:0] n);
    pick_t p;
    p = '0;
    for (int i = READY_WIDTH - 1; i >= 0; i--) begin
      if (ready[i] && (4'(i) < n)) begin
        p.found = 1'b1;
        p.idx   = 3'(i);
      end
    end
    pick_unit = p;
  endfunction

endpackage

// ===== design/iqd_fifo.sv =====
module iqd_fifo import iqd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head_data,
  output logic   empty,
  output logic   full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [AW:0]     count;
  logic [AW-1:0]   head_inc;
  logic [AW-1:0]   tail_inc;
  logic [AW-1:0]   rd_addr;

  assign head_inc = (head == LAST_ADDR) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_ADDR) ? '0 : tail + 1'b1;
  assign empty    = (count == '0);
  assign full     = (count == (AW+1)'(DEPTH));

  // The head entry is read ahead into a register. A push into an empty queue
  // lands on the address being read, so its data is forwarded.
  assign rd_addr = pop ? head_inc : head;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (push && (tail == rd_addr)) begin
      head_data <= push_data;
    end else begin
      head_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail  <= tail_inc;
        count <= count + 1'b1;
      end else if (pop) begin
        head  <= head_inc;
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/iqd_res_buf.sv =====
module iqd_res_buf import iqd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_t       load_data [RES_SLOTS],
  input  logic [1:0] load_count,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data
);

  res_t       slots [RES_SLOTS];
  logic [1:0] rd;
  logic [1:0] left;
  logic       take;

  assign out_valid = (left != 2'd0);
  assign out_data  = slots[rd];
  assign take      = out_valid && !out_stall;
  // A new set of results may enter as the last pending one leaves.
  assign can_load  = (left == 2'd0) || ((left == 2'd1) && !out_stall);

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd   <= '0;
      left <= '0;
    end else if (load) begin
      rd   <= '0;
      left <= load_count;
    end else if (take) begin
      rd   <= rd + 1'b1;
      left <= left - 1'b1;
    end
  end

endmodule

// ===== design/issue_queue_dispatcher_top.sv =====
// Issue stage with three in-order queues (vector, matrix, memory).
// Input channel (in_valid/in_stall/in_data) carries issue, tick and
// completion requests; output channel (out_valid/out_stall/out_data)
// returns one to three results per request, the final one marked by last.
// A request is decided in the cycle it is accepted: queue pushes, head pops,
// the ready-unit priority encode and the free-counter updates all happen at
// that clock edge, and its results reach the output in the next cycle.
// One request per cycle is taken when it yields a single result and the
// receiver does not stall; a tick that sends two or three ops holds input
// until its last result is leaving; the buffer drains one result per cycle.
// When the receiver stalls, the pending result holds; in_stall is high while
// more than one result is waiting, or while the last one is held by a stall.
// Configuration writes (cfg_valid/cfg_ready) set the active unit counts
// and reload the matching free counter; they are taken in any cycle.
// Reset empties all queues, sets both active counts to eight and the free
// counters to the clamped active counts; queue storage is not cleared.
module issue_queue_dispatcher_top import iqd_pkg::*; #(
  parameter int QUEUE_DEPTH      = 16,
  parameter int MAX_VECTOR_UNITS = 8,
  parameter int MAX_MATRIX_UNITS = 8,
  parameter int MAX_THREADS      = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam logic [3:0] VEC_LIM = 4'((MAX_VECTOR_UNITS < 8) ? MAX_VECTOR_UNITS : 8);
  localparam logic [3:0] MAT_LIM = 4'((MAX_MATRIX_UNITS < 8) ? MAX_MATRIX_UNITS : 8);

  logic [3:0] active_vector;
  logic [3:0] active_matrix;
  logic [3:0] free_vector;
  logic [3:0] free_matrix;
  logic [3:0] free_vector_next;
  logic [3:0] free_matrix_next;
  logic [3:0] nv;
  logic [3:0] nm;

  logic       accept;
  logic       can_load;
  logic       cfg_write;

  entry_t     new_entry;
  entry_t     vec_head;
  entry_t     mat_head;
  entry_t     mem_head;
  logic       vec_empty, mat_empty, mem_empty;
  logic       vec_full, mat_full, mem_full;
  logic       vec_push, mat_push, mem_push;
  logic       vec_go, mat_go, mem_go;
  logic       is_issue, is_tick;
  logic       thread_ok;
  pick_t      vec_pick;
  pick_t      mat_pick;

  res_t       res [RES_SLOTS];
  logic [1:0] res_count;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = !can_load;
  assign accept    = in_valid && can_load;

  assign nv = eff_count(active_vector, VEC_LIM);
  assign nm = eff_count(active_matrix, MAT_LIM);

  assign is_issue = accept && (in_data.req_type == REQ_ISSUE);
  assign is_tick  = accept && (in_data.req_type == REQ_TICK);

  assign new_entry.tag    = in_data.op_tag;
  assign new_entry.stream = in_data.stream_id;
  assign new_entry.thread = in_data.op_thread;

  assign vec_push = is_issue && (in_data.op_target == TGT_VECTOR) && !vec_full;
  assign mat_push = is_issue && (in_data.op_target == TGT_MATRIX) && !mat_full;
  assign mem_push = is_issue && (in_data.op_target == TGT_MEMORY) && !mem_full;

  assign vec_pick  = pick_unit(in_data.vector_ready, nv);
  assign mat_pick  = pick_unit(in_data.matrix_ready, nm);
  assign thread_ok = (int'(mem_head.thread) < MAX_THREADS) &&
                     in_data.mem_thread_ready[mem_head.thread];

  assign vec_go = is_tick && !vec_empty && (free_vector != 4'd0) && vec_pick.found;
  assign mat_go = is_tick && !mat_empty && (free_matrix != 4'd0) && mat_pick.found;
  assign mem_go = is_tick && !mem_empty && thread_ok;

  iqd_fifo #(.DEPTH(QUEUE_DEPTH)) u_vec_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (vec_push),
    .push_data (new_entry),
    .pop       (vec_go),
    .head_data (vec_head),
    .empty     (vec_empty),
    .full      (vec_full)
  );

  iqd_fifo #(.DEPTH(QUEUE_DEPTH)) u_mat_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mat_push),
    .push_data (new_entry),
    .pop       (mat_go),
    .head_data (mat_head),
    .empty     (mat_empty),
    .full      (mat_full)
  );

  iqd_fifo #(.DEPTH(QUEUE_DEPTH)) u_mem_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mem_push),
    .push_data (new_entry),
    .pop       (mem_go),
    .head_data (mem_head),
    .empty     (mem_empty),
    .full      (mem_full)
  );

  // Result list for the accepted request, packed from slot zero.
  always_comb begin
    res_t r_vec, r_mat, r_mem, r_one;
    logic [1:0] n;
    r_vec = '0;
    r_mat = '0;
    r_mem = '0;
    r_one = '0;
    n     = '0;
    for (int i = 0; i < RES_SLOTS; i++) begin
      res[i] = '0;
    end

    r_vec.res_kind   = KIND_VEC_DISP;
    r_vec.unit_index = vec_pick.idx;
    r_vec.out_tag    = vec_head.tag;
    r_vec.out_stream = vec_head.stream;
    r_vec.out_thread = vec_head.thread;

    r_mat.res_kind   = KIND_MAT_DISP;
    r_mat.unit_index = mat_pick.idx;
    r_mat.out_tag    = mat_head.tag;
    r_mat.out_stream = mat_head.stream;
    r_mat.out_thread = mat_head.thread;

    r_mem.res_kind   = KIND_MEM_SEND;
    r_mem.out_tag    = mem_head.tag;
    r_mem.out_stream = mem_head.stream;
    r_mem.out_thread = mem_head.thread;

    unique case (in_data.req_type)
      REQ_ISSUE: begin
        r_one.out_tag    = in_data.op_tag;
        r_one.out_stream = in_data.stream_id;
        r_one.out_thread = in_data.op_thread;
        if (in_data.op_target == TGT_INVALID) begin
          r_one.res_kind = KIND_BAD_TARGET;
        end else if (vec_push || mat_push || mem_push) begin
          r_one.res_kind = KIND_ACCEPTED;
        end else begin
          r_one.res_kind = KIND_QUEUE_FULL;
        end
      end
      REQ_VECTOR_DONE, REQ_MATRIX_DONE, REQ_MEMORY_DONE: begin
        r_one.res_kind   = KIND_NOTIFY;
        r_one.out_stream = in_data.stream_id;
      end
      default: begin
        r_one.res_kind = KIND_IDLE;
      end
    endcase

    if (is_tick) begin
      if (vec_go) begin
        res[n] = r_vec;
        n      = n + 1'b1;
      end
      if (mat_go) begin
        res[n] = r_mat;
        n      = n + 1'b1;
      end
      if (mem_go) begin
        res[n] = r_mem;
        n      = n + 1'b1;
      end
    end
    if (n == 2'd0) begin
      res[0] = r_one;
      n      = 2'd1;
    end
    res[n - 1'b1].last = 1'b1;
    res_count = n;
  end

  always_comb begin
    free_vector_next = free_vector;
    free_matrix_next = free_matrix;
    if (vec_go) begin
      free_vector_next = free_vector - 1'b1;
    end
    if (mat_go) begin
      free_matrix_next = free_matrix - 1'b1;
    end
    if (accept && (in_data.req_type == REQ_VECTOR_DONE) && (free_vector < nv)) begin
      free_vector_next = free_vector + 1'b1;
    end
    if (accept && (in_data.req_type == REQ_MATRIX_DONE) && (free_matrix < nm)) begin
      free_matrix_next = free_matrix + 1'b1;
    end
    if (cfg_write && (cfg_index == REG_ACTIVE_VECTOR)) begin
      free_vector_next = eff_count(cfg_data, VEC_LIM);
    end
    if (cfg_write && (cfg_index == REG_ACTIVE_MATRIX)) begin
      free_matrix_next = eff_count(cfg_data, MAT_LIM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_vector <= ACTIVE_RESET;
      active_matrix <= ACTIVE_RESET;
      free_vector   <= eff_count(ACTIVE_RESET, VEC_LIM);
      free_matrix   <= eff_count(ACTIVE_RESET, MAT_LIM);
    end else begin
      if (cfg_write && (cfg_index == REG_ACTIVE_VECTOR)) begin
        active_vector <= cfg_data;
      end
      if (cfg_write && (cfg_index == REG_ACTIVE_MATRIX)) begin
        active_matrix <= cfg_data;
      end
      free_vector <= free_vector_next;
      free_matrix <= free_matrix_next;
    end
  end

  iqd_res_buf u_res_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_data  (res),
    .load_count (res_count),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
